// ===== src/tpss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpss_pkg
// Shared types and constants for the throttled priority send scheduler.
// ----------------------------------------------------------------------------
package tpss_pkg;

  // Channel count and derived widths.
  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChanWidth   = $clog2(NumChannels);
  localparam int unsigned ChartChan   = 2;

  // Field widths.
  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned IntervalWidth = 16;
  localparam int unsigned SizeWidth     = 16;
  localparam int unsigned PrioWidth     = 8;
  localparam int unsigned MulWidth      = 8;
  localparam int unsigned CfgIdxWidth   = 4;
  localparam int unsigned CfgDataWidth  = 32;

  // Multiplier used when the configured one is zero.
  localparam logic [MulWidth-1:0] DefaultMul = MulWidth'(2);

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    RegStateInterval   = 4'd0,
    RegMetricsInterval = 4'd1,
    RegChartInterval   = 4'd2,
    RegSummaryInterval = 4'd3,
    RegPriorities      = 4'd4,
    RegLargePayload    = 4'd5,
    RegThrottleMul     = 4'd6,
    RegCleanupPeriod   = 4'd7
  } cfg_reg_e;

  // One scheduler tick request.
  typedef struct packed {
    logic [TimeWidth-1:0]   now_ms;
    logic [NumChannels-1:0] dirty_mask;
    logic [SizeWidth-1:0]   chart_payload_bytes;
  } in_item_t;

  // One scheduler result.
  typedef struct packed {
    logic                 send_valid;
    logic [ChanWidth-1:0] send_channel;
    logic                 cleanup_due;
  } out_item_t;

  // Current register settings.
  typedef struct packed {
    logic [NumChannels-1:0][IntervalWidth-1:0] interval;
    logic [NumChannels-1:0][PrioWidth-1:0]     prio;
    logic [SizeWidth-1:0]                      large_bytes;
    logic [MulWidth-1:0]                       mul;
    logic [IntervalWidth-1:0]                  cleanup_period;
  } cfg_t;

  // Decision of the channel picker.
  typedef struct packed {
    logic                 found;
    logic [ChanWidth-1:0] chan;
  } pick_t;

endpackage

// ===== src/throttled_priority_send_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttled_priority_send_scheduler_top
// Rate-limited fixed-priority scheduler over four send channels.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel is one scheduler tick carrying the time,
// new dirty bits and the chart payload size. Every tick yields exactly one
// result on the output channel: the channel sent, if any, and the cleanup
// pulse. Registers are written through the configuration channel, which is
// always ready; write them only while no tick is in flight.
// A request that is taken is held in the input register, decided from there
// and registered in the result register, which presents it on the output.
// Throughput is one tick per cycle while the receiver keeps up; the decision
// path (five 32-bit elapsed time compares, one 16x8 multiply and a four-way
// priority scan) sits between the input register and the result register.
// When the receiver stalls, the result is held and the input register still
// takes one more request; further requests wait until the result leaves.
// Reset clears pending flags, send and cleanup timestamps, the last chart
// size and both pipeline valids, and loads the register defaults.
// ----------------------------------------------------------------------------
module throttled_priority_send_scheduler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tpss_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tpss_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tpss_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [tpss_pkg::CfgDataWidth-1:0] cfg_data_i
);

  tpss_pkg::cfg_t     cfg;
  tpss_pkg::pick_t    pick;
  tpss_pkg::in_item_t in_q;
  logic               in_valid_q;
  logic               advance;

  tpss_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;

  logic [tpss_pkg::NumChannels-1:0]                          pending_q, pending_d;
  logic [tpss_pkg::NumChannels-1:0]                          merged;
  logic [tpss_pkg::NumChannels-1:0][tpss_pkg::TimeWidth-1:0] last_send_q, last_send_d;
  logic [tpss_pkg::SizeWidth-1:0]                            chart_size_q, chart_size_d;
  logic [tpss_pkg::TimeWidth-1:0]                            cleanup_time_q, cleanup_time_d;
  logic                                                      cleanup;

  assign cfg_ready_o = 1'b1;

  tpss_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the decision stage moves whenever the result slot is free.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Fold the new dirty bits into the pending flags before choosing.
  assign merged = pending_q | in_q.dirty_mask;

  tpss_picker u_picker (
    .cfg_i             (cfg),
    .now_i             (in_q.now_ms),
    .pending_i         (merged),
    .last_send_i       (last_send_q),
    .last_chart_size_i (chart_size_q),
    .pick_o            (pick)
  );

  // Cleanup timer on its own wrap-safe elapsed time.
  assign cleanup = (in_q.now_ms - cleanup_time_q) >=
                   {{(tpss_pkg::TimeWidth-tpss_pkg::IntervalWidth){1'b0}},
                    cfg.cleanup_period};

  // Next state and result for the tick in the decision stage.
  always_comb begin
    pending_d      = pending_q;
    last_send_d    = last_send_q;
    chart_size_d   = chart_size_q;
    cleanup_time_d = cleanup_time_q;
    out_d          = out_q;
    if (advance) begin
      pending_d = merged;
      if (pick.found) begin
        pending_d[pick.chan]   = 1'b0;
        last_send_d[pick.chan] = in_q.now_ms;
        if (pick.chan == tpss_pkg::ChanWidth'(tpss_pkg::ChartChan)) begin
          chart_size_d = in_q.chart_payload_bytes;
        end
      end
      if (cleanup) begin
        cleanup_time_d = in_q.now_ms;
      end
      out_d.send_valid   = pick.found;
      out_d.send_channel = pick.found ? pick.chan : '0;
      out_d.cleanup_due  = cleanup;
    end
  end

  // Control and scheduler state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      pending_q      <= '0;
      last_send_q    <= '0;
      chart_size_q   <= '0;
      cleanup_time_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      pending_q      <= pending_d;
      last_send_q    <= last_send_d;
      chart_size_q   <= chart_size_d;
      cleanup_time_q <= cleanup_time_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/tpss_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpss_cfg_regs
// Configuration register file with reset defaults and index decoding.
// ----------------------------------------------------------------------------
module tpss_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [tpss_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [tpss_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output tpss_pkg::cfg_t                       cfg_o
);

  tpss_pkg::cfg_t cfg_q, cfg_d;

  // Decode a write; unknown indexes leave every register unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tpss_pkg::RegStateInterval:
          cfg_d.interval[0] = cfg_data_i[tpss_pkg::IntervalWidth-1:0];
        tpss_pkg::RegMetricsInterval:
          cfg_d.interval[1] = cfg_data_i[tpss_pkg::IntervalWidth-1:0];
        tpss_pkg::RegChartInterval:
          cfg_d.interval[2] = cfg_data_i[tpss_pkg::IntervalWidth-1:0];
        tpss_pkg::RegSummaryInterval:
          cfg_d.interval[3] = cfg_data_i[tpss_pkg::IntervalWidth-1:0];
        tpss_pkg::RegPriorities:
          cfg_d.prio = cfg_data_i;
        tpss_pkg::RegLargePayload:
          cfg_d.large_bytes = cfg_data_i[tpss_pkg::SizeWidth-1:0];
        tpss_pkg::RegThrottleMul:
          cfg_d.mul = cfg_data_i[tpss_pkg::MulWidth-1:0];
        tpss_pkg::RegCleanupPeriod:
          cfg_d.cleanup_period = cfg_data_i[tpss_pkg::IntervalWidth-1:0];
        default: ;
      endcase
    end
  end

  // Registers with their power-on defaults.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval[0]    <= 16'd500;
      cfg_q.interval[1]    <= 16'd1000;
      cfg_q.interval[2]    <= 16'd2000;
      cfg_q.interval[3]    <= 16'd5000;
      cfg_q.prio           <= '0;
      cfg_q.large_bytes    <= 16'd4096;
      cfg_q.mul            <= 8'd2;
      cfg_q.cleanup_period <= 16'd2000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/tpss_picker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpss_picker
// Eligibility check and fixed-priority selection over the send channels.
// ----------------------------------------------------------------------------
module tpss_picker (
  input  tpss_pkg::cfg_t                                            cfg_i,
  input  logic [tpss_pkg::TimeWidth-1:0]                            now_i,
  input  logic [tpss_pkg::NumChannels-1:0]                          pending_i,
  input  logic [tpss_pkg::NumChannels-1:0][tpss_pkg::TimeWidth-1:0] last_send_i,
  input  logic [tpss_pkg::SizeWidth-1:0]                            last_chart_size_i,
  output tpss_pkg::pick_t                                           pick_o
);

  logic [tpss_pkg::MulWidth-1:0]                                  mul;
  logic [tpss_pkg::IntervalWidth+tpss_pkg::MulWidth-1:0]          stretched;
  logic [tpss_pkg::NumChannels-1:0][tpss_pkg::IntervalWidth-1:0] itv;
  logic [tpss_pkg::NumChannels-1:0]                               eligible;
  logic [tpss_pkg::PrioWidth-1:0]                                 best_prio;

  // The chart interval is stretched while the last chart payload was large.
  assign mul       = (cfg_i.mul != '0) ? cfg_i.mul : tpss_pkg::DefaultMul;
  assign stretched = cfg_i.interval[tpss_pkg::ChartChan] * mul;

  always_comb begin
    itv = cfg_i.interval;
    if (last_chart_size_i >= cfg_i.large_bytes) begin
      itv[tpss_pkg::ChartChan] = stretched[tpss_pkg::IntervalWidth-1:0];
    end
  end

  // A pending channel is eligible once its wrap-safe elapsed time reaches its interval.
  always_comb begin
    for (int i = 0; i < tpss_pkg::NumChannels; i++) begin
      eligible[i] = pending_i[i] &&
                    ((now_i - last_send_i[i]) >=
                     {{(tpss_pkg::TimeWidth-tpss_pkg::IntervalWidth){1'b0}}, itv[i]});
    end
  end

  // Smallest priority wins; scanning upward keeps the lower index on a tie.
  always_comb begin
    pick_o    = '0;
    best_prio = '0;
    for (int i = 0; i < tpss_pkg::NumChannels; i++) begin
      if (eligible[i] && (!pick_o.found || (cfg_i.prio[i] < best_prio))) begin
        pick_o.found = 1'b1;
        pick_o.chan  = tpss_pkg::ChanWidth'(i);
        best_prio    = cfg_i.prio[i];
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the throttled priority send scheduler.
// A directed table of ticks runs first under the reset, mostly-zero and
// all-ones register settings. Random segments follow under fresh settings
// and different handshake pressure. Each result is compared field by field
// with the bench's own model of the scheduler, or with a row's hand-typed result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ResultLatency = 2;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned Segments      = 8;
  localparam int unsigned SegmentTicks  = 130;
  localparam int unsigned DirectedRows  = 22;

  typedef enum logic [1:0] {
    PresetReset,
    PresetZero,
    PresetMax
  } preset_e;

  // One directed request, with its result where it is typed in by hand.
  typedef struct packed {
    preset_e             preset;
    logic                typed;
    tpss_pkg::out_item_t result;
    tpss_pkg::in_item_t  tick;
  } row_t;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  tpss_pkg::in_item_t                in_item   = '0;
  logic                              out_ready = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic [tpss_pkg::CfgIdxWidth-1:0]  cfg_index = '0;
  logic [tpss_pkg::CfgDataWidth-1:0] cfg_data  = '0;
  logic                              in_ready;
  logic                              out_valid;
  logic                              cfg_ready;
  tpss_pkg::out_item_t               out_item;

  // The hand-typed result travels with the request it belongs to.
  logic                tick_typed  = 1'b0;
  tpss_pkg::out_item_t tick_result = '0;

  // Scheduler model: settings and state.
  tpss_pkg::cfg_t                   active_cfg;
  logic [tpss_pkg::NumChannels-1:0] pending;
  logic [tpss_pkg::TimeWidth-1:0]   last_sent_ms [tpss_pkg::NumChannels];
  logic [tpss_pkg::SizeWidth-1:0]   last_chart_bytes;
  logic [tpss_pkg::TimeWidth-1:0]   last_cleanup_ms;

  tpss_pkg::out_item_t decision_q[$];
  row_t                tick_rows [DirectedRows];
  int unsigned         fail_count     = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;

  throttled_priority_send_scheduler_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // Abort the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Folds in the dirty bits, picks the channel to send and fires the cleanup
  // timer, updating the model state the way one tick does.
  function automatic tpss_pkg::out_item_t pick_and_send(input tpss_pkg::in_item_t t);
    tpss_pkg::out_item_t                res;
    logic                               found;
    logic [tpss_pkg::ChanWidth-1:0]     best;
    logic [tpss_pkg::PrioWidth+3:0]     key;
    logic [tpss_pkg::PrioWidth+3:0]     best_key;
    logic [tpss_pkg::IntervalWidth-1:0] gap_ms;
    logic [23:0]                        stretched;
    logic [tpss_pkg::MulWidth-1:0]      mul;
    found    = 1'b0;
    best     = '0;
    best_key = '0;
    pending  = pending | t.dirty_mask;
    for (int i = 0; i < tpss_pkg::NumChannels; i++) begin
      gap_ms = active_cfg.interval[i];
      // The chart interval stretches while the last chart sent was large.
      if (i == tpss_pkg::ChartChan && last_chart_bytes >= active_cfg.large_bytes) begin
        mul       = (active_cfg.mul != '0) ? active_cfg.mul : tpss_pkg::DefaultMul;
        stretched = gap_ms * mul;
        gap_ms    = stretched[tpss_pkg::IntervalWidth-1:0];
      end
      key = {active_cfg.prio[i], 4'(i)};
      if (pending[i] && (t.now_ms - last_sent_ms[i]) >= gap_ms &&
          (!found || key < best_key)) begin
        found    = 1'b1;
        best     = tpss_pkg::ChanWidth'(i);
        best_key = key;
      end
    end
    if (found) begin
      if (best == tpss_pkg::ChanWidth'(tpss_pkg::ChartChan)) begin
        last_chart_bytes = t.chart_payload_bytes;
      end
      last_sent_ms[best] = t.now_ms;
      pending[best]      = 1'b0;
    end
    res.send_valid   = found;
    res.send_channel = best;
    res.cleanup_due  = (t.now_ms - last_cleanup_ms) >= active_cfg.cleanup_period;
    if (res.cleanup_due) begin
      last_cleanup_ms = t.now_ms;
    end
    return res;
  endfunction

  // Every accepted request queues its expected result.
  always @(posedge clk) begin : tick_monitor
    tpss_pkg::out_item_t predicted;
    if (rst_n && in_valid && in_ready) begin
      predicted = pick_and_send(in_item);
      decision_q.push_back(tick_typed ? tick_result : predicted);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    tpss_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decision_q.size() == 0) begin
        $error("unexpected result %h with nothing outstanding", out_item);
        fail_count++;
      end else begin
        want = decision_q.pop_front();
        if (out_item.send_valid !== want.send_valid) begin
          $error("send_valid: expected %0d, actual %0d", want.send_valid,
                 out_item.send_valid);
          fail_count++;
        end
        if (out_item.send_channel !== want.send_channel) begin
          $error("send_channel: expected %0d, actual %0d", want.send_channel,
                 out_item.send_channel);
          fail_count++;
        end
        if (out_item.cleanup_due !== want.cleanup_due) begin
          $error("cleanup_due: expected %0d, actual %0d", want.cleanup_due,
                 out_item.cleanup_due);
          fail_count++;
        end
      end
    end
  end

  function automatic row_t mk_row(input preset_e p, input logic typed,
                                  input logic sv, input int unsigned ch,
                                  input logic cd,
                                  input logic [tpss_pkg::TimeWidth-1:0] now,
                                  input logic [tpss_pkg::NumChannels-1:0] dirty,
                                  input logic [tpss_pkg::SizeWidth-1:0] bytes);
    row_t r;
    r.preset                   = p;
    r.typed                    = typed;
    r.result.send_valid        = sv;
    r.result.send_channel      = tpss_pkg::ChanWidth'(ch);
    r.result.cleanup_due       = cd;
    r.tick.now_ms              = now;
    r.tick.dirty_mask          = dirty;
    r.tick.chart_payload_bytes = bytes;
    return r;
  endfunction

  // Presents one request and holds it until it is taken, then idles the
  // sender at random for the current phase.
  task automatic put_tick(input tpss_pkg::in_item_t t, input logic typed,
                          input tpss_pkg::out_item_t res);
    in_valid    <= 1'b1;
    in_item     <= t;
    tick_typed  <= typed;
    tick_result <= res;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decision_q.size() != 0) @(posedge clk);
    repeat (ResultLatency + 2) @(posedge clk);
  endtask

  // One register write; the model takes the same value once it is accepted.
  task automatic write_reg(input logic [tpss_pkg::CfgIdxWidth-1:0] idx,
                           input logic [tpss_pkg::CfgDataWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx) inside
      tpss_pkg::RegStateInterval, tpss_pkg::RegMetricsInterval,
      tpss_pkg::RegChartInterval, tpss_pkg::RegSummaryInterval: begin
        active_cfg.interval[idx[tpss_pkg::ChanWidth-1:0]] =
            data[tpss_pkg::IntervalWidth-1:0];
      end
      tpss_pkg::RegPriorities: active_cfg.prio = data;
      tpss_pkg::RegLargePayload: active_cfg.large_bytes = data[tpss_pkg::SizeWidth-1:0];
      tpss_pkg::RegThrottleMul: active_cfg.mul = data[tpss_pkg::MulWidth-1:0];
      tpss_pkg::RegCleanupPeriod:
        active_cfg.cleanup_period = data[tpss_pkg::IntervalWidth-1:0];
      default: ;
    endcase
  endtask

  // Writes a full register set, then one write to an unused index that must
  // leave everything unchanged.
  task automatic apply_settings(input tpss_pkg::cfg_t s);
    for (int i = 0; i < tpss_pkg::NumChannels; i++) begin
      write_reg(tpss_pkg::CfgIdxWidth'(tpss_pkg::RegStateInterval) +
                tpss_pkg::CfgIdxWidth'(i),
                tpss_pkg::CfgDataWidth'(s.interval[i]));
    end
    write_reg(tpss_pkg::RegPriorities, s.prio);
    write_reg(tpss_pkg::RegLargePayload, tpss_pkg::CfgDataWidth'(s.large_bytes));
    write_reg(tpss_pkg::RegThrottleMul, tpss_pkg::CfgDataWidth'(s.mul));
    write_reg(tpss_pkg::RegCleanupPeriod, tpss_pkg::CfgDataWidth'(s.cleanup_period));
    write_reg(tpss_pkg::CfgIdxWidth'(tpss_pkg::RegCleanupPeriod) +
              tpss_pkg::CfgIdxWidth'($urandom_range(1, 8)),
              $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    tpss_pkg::cfg_t                 s;
    tpss_pkg::in_item_t             t;
    logic [tpss_pkg::TimeWidth-1:0] clock_ms;

    // Model state after reset.
    active_cfg.interval[0]    = 16'd500;
    active_cfg.interval[1]    = 16'd1000;
    active_cfg.interval[2]    = 16'd2000;
    active_cfg.interval[3]    = 16'd5000;
    active_cfg.prio           = '0;
    active_cfg.large_bytes    = 16'd4096;
    active_cfg.mul            = 8'd2;
    active_cfg.cleanup_period = 16'd2000;
    pending                   = '0;
    foreach (last_sent_ms[i]) last_sent_ms[i] = '0;
    last_chart_bytes          = '0;
    last_cleanup_ms           = '0;

    // Reset settings: results follow directly from the default intervals,
    // including the wrap of the time counter.
    tick_rows[0]  = mk_row(PresetReset, 1, 0, 0, 0, 32'd0, 4'h0, 16'd0);
    tick_rows[1]  = mk_row(PresetReset, 1, 0, 0, 0, 32'd100, 4'hF, 16'd0);
    tick_rows[2]  = mk_row(PresetReset, 1, 1, 0, 0, 32'd500, 4'h0, 16'd0);
    tick_rows[3]  = mk_row(PresetReset, 1, 1, 1, 0, 32'd1000, 4'h0, 16'd0);
    tick_rows[4]  = mk_row(PresetReset, 1, 1, 2, 1, 32'd2000, 4'h0, 16'hFFFF);
    tick_rows[5]  = mk_row(PresetReset, 1, 1, 2, 1, 32'hFFFF_FFFF, 4'h4, 16'd0);
    tick_rows[6]  = mk_row(PresetReset, 1, 0, 0, 0, 32'd0, 4'h0, 16'd0);
    tick_rows[7]  = mk_row(PresetReset, 1, 1, 3, 1, 32'd5000, 4'h0, 16'd0);
    // Zero intervals, zero multiplier, zero cleanup period, distinct priorities.
    tick_rows[8]  = mk_row(PresetZero, 0, 0, 0, 0, 32'd10, 4'hF, 16'hFFFF);
    tick_rows[9]  = mk_row(PresetZero, 0, 0, 0, 0, 32'd10, 4'h0, 16'h1234);
    tick_rows[10] = mk_row(PresetZero, 0, 0, 0, 0, 32'd10, 4'h0, 16'd0);
    tick_rows[11] = mk_row(PresetZero, 0, 0, 0, 0, 32'd11, 4'h5, 16'hFFFF);
    tick_rows[12] = mk_row(PresetZero, 0, 0, 0, 0, 32'd11, 4'h0, 16'd0);
    tick_rows[13] = mk_row(PresetZero, 0, 0, 0, 0, 32'd12, 4'h8, 16'd0);
    tick_rows[14] = mk_row(PresetZero, 0, 0, 0, 0, 32'd12, 4'h0, 16'd0);
    // All registers at their maximum: tied priorities and a stretched chart
    // interval that overflows 16 bits.
    tick_rows[15] = mk_row(PresetMax, 0, 0, 0, 0, 32'd0, 4'hF, 16'hFFFF);
    tick_rows[16] = mk_row(PresetMax, 0, 0, 0, 0, 32'h0000_FFFF, 4'h0, 16'hFFFF);
    tick_rows[17] = mk_row(PresetMax, 0, 0, 0, 0, 32'h0001_0000, 4'h0, 16'hFFFF);
    tick_rows[18] = mk_row(PresetMax, 0, 0, 0, 0, 32'h0001_FF00, 4'h0, 16'd0);
    tick_rows[19] = mk_row(PresetMax, 0, 0, 0, 0, 32'h8000_0000, 4'hF, 16'hAAAA);
    tick_rows[20] = mk_row(PresetMax, 0, 0, 0, 0, 32'hFFFF_FFFF, 4'h0, 16'hFFFF);
    tick_rows[21] = mk_row(PresetMax, 0, 0, 0, 0, 32'h7FFF_FFFF, 4'h0, 16'h5555);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int r = 0; r < DirectedRows; r++) begin
      if (r > 0 && tick_rows[r].preset != tick_rows[r-1].preset) begin
        drain_results();
        if (tick_rows[r].preset == PresetZero) begin
          s.interval       = '0;
          s.prio           = 32'h0001_0203;
          s.large_bytes    = '0;
          s.mul            = '0;
          s.cleanup_period = '0;
        end else begin
          s = '1;
        end
        apply_settings(s);
      end
      put_tick(tick_rows[r].tick, tick_rows[r].typed, tick_rows[r].result);
    end

    // Random segments, each with new settings and its own handshake pressure.
    for (int seg = 0; seg < Segments; seg++) begin
      drain_results();
      case (seg % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct  = 11;
          recv_stall_pct = 11;
        end
      endcase
      for (int c = 0; c < tpss_pkg::NumChannels; c++) begin
        case ($urandom_range(0, 9))
          0: s.interval[c] = '0;
          1: s.interval[c] = '1;
          2: s.interval[c] = 16'($urandom);
          default: s.interval[c] = 16'($urandom_range(1, 150));
        endcase
      end
      s.prio        = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
      s.large_bytes = 16'($urandom);
      s.mul         = ($urandom_range(0, 3) == 0) ? '0 : 8'($urandom);
      case ($urandom_range(0, 5))
        0: s.cleanup_period = '0;
        1: s.cleanup_period = '1;
        default: s.cleanup_period = 16'($urandom_range(1, 300));
      endcase
      apply_settings(s);

      // Start half of the segments just short of the time wrap.
      clock_ms = (seg % 2 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
      for (int k = 0; k < SegmentTicks; k++) begin
        // Hold off once mid-segment until every result is back.
        if (k == SegmentTicks / 2) begin
          drain_results();
        end
        // Time mostly moves forward in small steps, with rare jumps.
        case ($urandom_range(0, 19))
          0: clock_ms = $urandom;
          1: clock_ms += $urandom_range(0, 65535);
          default: clock_ms += $urandom_range(0, 40);
        endcase
        t.now_ms     = clock_ms;
        t.dirty_mask = ($urandom_range(0, 3) == 0) ? 4'($urandom) :
                                                     4'($urandom & $urandom);
        // Chart sizes land around the large threshold a quarter of the time.
        t.chart_payload_bytes = ($urandom_range(0, 3) == 0) ?
            s.large_bytes + 16'($urandom_range(0, 2)) - 16'd1 : 16'($urandom);
        put_tick(t, 1'b0, '0);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
